// ----- sv/pcm_audio_depacketizer_top_defines.svh -----
// -----------------------------------------------------------------------------
// PCM depacketizer assertion macros
// Shared property wrappers for the checker; clock is clk, reset is rst_n.
// -----------------------------------------------------------------------------
`ifndef PCM_AUDIO_DEPACKETIZER_TOP_DEFINES_SVH
`define PCM_AUDIO_DEPACKETIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PCM_DP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PCM_DP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pcm_dp_pkg.sv -----
// -----------------------------------------------------------------------------
// PCM depacketizer package
// Field widths, register codes and reset values shared by the block's files.
// -----------------------------------------------------------------------------
package pcm_dp_pkg;

    localparam int BPS_W   = 2;
    localparam int FPB_W   = 14;
    localparam int CH_W    = 4;
    localparam int CFG_W   = 14;
    localparam int SEC_W   = 32;
    localparam int US_W    = 20;
    localparam int TS_W    = 32;
    localparam int DUR_W   = 32;
    localparam int SMP_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int PROD_W  = FPB_W + CH_W;

    // stream payload widths (already whole bytes)
    localparam int IN_TDATA_W  = BYTE_W + TS_W + 2 * (SEC_W + US_W) + DUR_W;
    localparam int OUT_TDATA_W = SMP_W + TS_W + 2 * (SEC_W + US_W) + DUR_W;

    localparam logic [US_W-1:0] US_PER_SECOND = US_W'(1000000);

    // sample width codes
    localparam logic [BPS_W-1:0] BPS_16 = 2'd2;
    localparam logic [BPS_W-1:0] BPS_24 = 2'd3;

    localparam logic [BPS_W-1:0] BPS_RESET = BPS_24;
    localparam logic [FPB_W-1:0] FPB_RESET = 14'd256;
    localparam logic [CH_W-1:0]  CH_RESET  = 4'd2;

    typedef enum logic [1:0] {
        CFG_BYTES_PER_SAMPLE = 2'd0,
        CFG_FRAMES_PER_BLOCK = 2'd1,
        CFG_CHANNEL_COUNT    = 2'd2
    } cfg_reg_t;

    // per-sample command to a time accumulator
    typedef struct packed {
        logic load;     // first sample of a block: take packet time
        logic advance;  // later sample: step one sample period
        logic carry;    // extra microsecond from the fraction
    } time_ctl_t;

endpackage

// ----- sv/pcm_dp_time.sv -----
// -----------------------------------------------------------------------------
// PCM depacketizer time accumulator
// Holds seconds and whole microseconds; latches a packet time or steps it.
// -----------------------------------------------------------------------------
module pcm_dp_time #(
    parameter int STEP_WHOLE_US = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pcm_dp_pkg::time_ctl_t  ctl,
    input  logic [31:0]            sec_in,
    input  logic [19:0]            usec_in,
    output logic [31:0]            sec_next,
    output logic [19:0]            usec_next
);
    import pcm_dp_pkg::*;

    logic [SEC_W-1:0] sec_reg;
    logic [US_W-1:0]  usec_reg;
    logic [SEC_W-1:0] sec_lat;
    logic [US_W-1:0]  usec_lat;
    logic [US_W:0]    usec_sum;
    logic [SEC_W-1:0] sec_step;
    logic [US_W-1:0]  usec_step;

    // fold an out-of-range microseconds value into the seconds
    always_comb
    begin
        if (usec_in >= US_PER_SECOND)
        begin
            usec_lat = usec_in - US_PER_SECOND;
            sec_lat  = sec_in + SEC_W'(1);
        end
        else
        begin
            usec_lat = usec_in;
            sec_lat  = sec_in;
        end
    end

    always_comb
    begin
        usec_sum = {1'b0, usec_reg} + (US_W+1)'(STEP_WHOLE_US) + (US_W+1)'(ctl.carry);
        if (usec_sum >= {1'b0, US_PER_SECOND})
        begin
            usec_step = US_W'(usec_sum - {1'b0, US_PER_SECOND});
            sec_step  = sec_reg + SEC_W'(1);
        end
        else
        begin
            usec_step = usec_sum[US_W-1:0];
            sec_step  = sec_reg;
        end
    end

    always_comb
    begin
        if (ctl.load)
        begin
            sec_next  = sec_lat;
            usec_next = usec_lat;
        end
        else if (ctl.advance)
        begin
            sec_next  = sec_step;
            usec_next = usec_step;
        end
        else
        begin
            sec_next  = sec_reg;
            usec_next = usec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg  <= '0;
            usec_reg <= '0;
        end
        else if (ctl.load || ctl.advance)
        begin
            sec_reg  <= sec_next;
            usec_reg <= usec_next;
        end
    end

endmodule

// ----- sv/pcm_audio_depacketizer_top.sv -----
// -----------------------------------------------------------------------------
// PCM audio depacketizer
// Builds Q1.23 samples from RTP L16/L24 payload bytes and tags block ends.
// -----------------------------------------------------------------------------
// Throughput: one payload byte per cycle; s_axis_tready drops only while a
//   result sits in the skid stage behind a stalled output register.
// Output: the result of the byte that completes a sample is registered in the
//   output register, or in the skid stage while the output is stalled.
// Reset (rst_n low, asynchronous): registers return to 24-bit samples,
//   256 frames, 2 channels; counters, phase and output valids clear.
module pcm_audio_depacketizer_top #(
    parameter int SAMPLE_RATE_HZ    = 48000,
    parameter int MAX_BLOCK_SAMPLES = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [13:0]  cfg_data,
    // byte request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, low bit up: data_byte[8], rtp_timestamp[32], pres_seconds[32],
    //   pres_micros[20], tx_seconds[32], tx_micros[20], packet_duration[32]
    input  logic [175:0] s_axis_tdata,
    // tuser: packet_start
    input  logic         s_axis_tuser,
    // sample result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: sample_value[24], block_timestamp[32],
    //   block_pres_seconds[32], block_pres_micros[20], block_tx_seconds[32],
    //   block_tx_micros[20], block_duration[32]
    output logic [191:0] m_axis_tdata,
    // tlast: block_end
    output logic         m_axis_tlast
);
    import pcm_dp_pkg::*;

    // one sample period, split into whole microseconds and a remainder kept
    // in units of 1/SAMPLE_RATE_HZ microsecond
    localparam int STEP_WHOLE_US = 1000000 / SAMPLE_RATE_HZ;
    localparam int STEP_FRAC     = 1000000 % SAMPLE_RATE_HZ;
    localparam int REM_W         = $clog2(SAMPLE_RATE_HZ);
    localparam int CNT_W         = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam logic [PROD_W-1:0] MAX_P = PROD_W'(MAX_BLOCK_SAMPLES);

    // configuration
    logic [BPS_W-1:0] bps_reg;
    logic [FPB_W-1:0] fpb_reg;
    logic [CH_W-1:0]  ch_reg;

    // per-byte state
    logic [1:0]       phase_reg;
    logic [1:0]       phase_base;
    logic [1:0]       phase_inc;
    logic [15:0]      partial_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_inc;
    logic [TS_W-1:0]  ts_reg;
    logic [TS_W-1:0]  ts_next;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W:0]   rem_sum;
    logic [REM_W-1:0] rem_step;
    logic             rem_carry;

    // unpacked input fields
    logic             in_accept;
    logic [BYTE_W-1:0] in_byte;
    logic [TS_W-1:0]  in_ts;
    logic [SEC_W-1:0] in_pres_s;
    logic [US_W-1:0]  in_pres_us;
    logic [SEC_W-1:0] in_tx_s;
    logic [US_W-1:0]  in_tx_us;
    logic [DUR_W-1:0] in_dur;

    logic             take;
    logic             sample_done;
    logic             first;
    logic             block_done;
    logic [SMP_W-1:0] sample;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] target_full;
    logic [CNT_W-1:0] target;
    time_ctl_t        tctl;

    logic [SEC_W-1:0] pres_s_next;
    logic [US_W-1:0]  pres_us_next;
    logic [SEC_W-1:0] tx_s_next;
    logic [US_W-1:0]  tx_us_next;

    logic [OUT_TDATA_W-1:0] res_data;

    // output register and skid stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [OUT_TDATA_W-1:0] skid_data_reg;
    logic                   skid_last_reg;
    logic                   out_load_new;
    logic                   out_load_skid;
    logic                   skid_load;

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign in_byte    = s_axis_tdata[7:0];
    assign in_ts      = s_axis_tdata[39:8];
    assign in_pres_s  = s_axis_tdata[71:40];
    assign in_pres_us = s_axis_tdata[91:72];
    assign in_tx_s    = s_axis_tdata[123:92];
    assign in_tx_us   = s_axis_tdata[143:124];
    assign in_dur     = s_axis_tdata[175:144];

    // ---------------------------------------------------------------------
    // Configuration writes; an index past the list is dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= BPS_RESET;
            fpb_reg <= FPB_RESET;
            ch_reg  <= CH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_BYTES_PER_SAMPLE: bps_reg <= cfg_data[BPS_W-1:0];
                CFG_FRAMES_PER_BLOCK: fpb_reg <= cfg_data[FPB_W-1:0];
                CFG_CHANNEL_COUNT:    ch_reg  <= cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Byte assembly. Widths below 16 bits ignore the byte outright; a packet
    // start drops whatever partial sample was held.
    // ---------------------------------------------------------------------
    assign take        = in_accept && (bps_reg >= BPS_16);
    assign phase_base  = s_axis_tuser ? 2'd0 : phase_reg;
    assign phase_inc   = phase_base + 2'd1;
    assign sample_done = take && (phase_inc >= bps_reg);

    // big-endian; 16-bit samples land in the top of the Q1.23 word
    assign sample = (bps_reg == BPS_16) ? {partial_reg[7:0], in_byte, 8'h00}
                                        : {partial_reg, in_byte};

    // ---------------------------------------------------------------------
    // Block counting: size is frames times channels, at least one, at most
    // MAX_BLOCK_SAMPLES. Reaching or passing the size ends the block.
    // ---------------------------------------------------------------------
    assign prod = PROD_W'(fpb_reg) * PROD_W'(ch_reg);

    always_comb
    begin
        if (prod == '0)
            target_full = PROD_W'(1);
        else if (prod > MAX_P)
            target_full = MAX_P;
        else
            target_full = prod;
    end

    assign target     = target_full[CNT_W-1:0];
    assign first      = (cnt_reg == '0);
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign block_done = cnt_inc >= target;

    // ---------------------------------------------------------------------
    // Sample-period fraction; a wrap adds one microsecond to both times.
    // ---------------------------------------------------------------------
    always_comb
    begin
        rem_sum = {1'b0, rem_reg} + (REM_W+1)'(STEP_FRAC);
        if (rem_sum >= (REM_W+1)'(SAMPLE_RATE_HZ))
        begin
            rem_step  = REM_W'(rem_sum - (REM_W+1)'(SAMPLE_RATE_HZ));
            rem_carry = 1'b1;
        end
        else
        begin
            rem_step  = rem_sum[REM_W-1:0];
            rem_carry = 1'b0;
        end
    end

    assign tctl.load    = sample_done && first;
    assign tctl.advance = sample_done && !first;
    assign tctl.carry   = rem_carry;

    assign ts_next = first ? in_ts : ts_reg + TS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            partial_reg <= '0;
            cnt_reg     <= '0;
            ts_reg      <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= sample_done ? 2'd0 : phase_inc;
                partial_reg <= {partial_reg[7:0], in_byte};
            end
            if (sample_done)
            begin
                cnt_reg <= block_done ? '0 : cnt_inc;
                ts_reg  <= ts_next;
                rem_reg <= first ? '0 : rem_step;
            end
        end
    end

    pcm_dp_time #(
        .STEP_WHOLE_US (STEP_WHOLE_US)
    ) u_pres_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tctl),
        .sec_in    (in_pres_s),
        .usec_in   (in_pres_us),
        .sec_next  (pres_s_next),
        .usec_next (pres_us_next)
    );

    pcm_dp_time #(
        .STEP_WHOLE_US (STEP_WHOLE_US)
    ) u_tx_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tctl),
        .sec_in    (in_tx_s),
        .usec_in   (in_tx_us),
        .sec_next  (tx_s_next),
        .usec_next (tx_us_next)
    );

    // descriptor fields read zero except on the sample that ends a block
    always_comb
    begin
        if (block_done)
            res_data = {in_dur, tx_us_next, tx_s_next, pres_us_next, pres_s_next,
                        ts_next, sample};
        else
            res_data = {(OUT_TDATA_W-SMP_W)'(0), sample};
    end

    // ---------------------------------------------------------------------
    // Output register with skid stage. A new result goes straight to the
    // output when it is free or being taken; otherwise park it in the skid
    // stage and hold the input until the output drains.
    // ---------------------------------------------------------------------
    always_comb
    begin
        out_load_new  = sample_done && (!out_valid_reg || m_axis_tready);
        skid_load     = sample_done && out_valid_reg && !m_axis_tready;
        out_load_skid = skid_valid_reg && m_axis_tready;

        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_load_new || out_load_skid)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        if (skid_load)
            skid_valid_next = 1'b1;
        else if (out_load_skid)
            skid_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_new)
        begin
            out_data_reg <= res_data;
            out_last_reg <= block_done;
        end
        else if (out_load_skid)
        begin
            out_data_reg <= skid_data_reg;
            out_last_reg <= skid_last_reg;
        end
        if (skid_load)
        begin
            skid_data_reg <= res_data;
            skid_last_reg <= block_done;
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- sv/pcm_dp_checker.sv -----
// -----------------------------------------------------------------------------
// PCM depacketizer port checker
// Watches the top level's ports and flags results that break the contract.
// -----------------------------------------------------------------------------
`include "pcm_audio_depacketizer_top_defines.svh"

module pcm_dp_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tready,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [191:0] m_axis_tdata,
    input  logic         m_axis_tlast
);
    import pcm_dp_pkg::*;

    // hold a stalled result
    `PCM_DP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled result changed")

    // the input only stalls when a result is waiting at the output
    `PCM_DP_ASSERT_NOW(a_stall_has_result, !s_axis_tready, m_axis_tvalid,
        "input stalled with empty output")

    // descriptor fields are zero inside a block
    `PCM_DP_ASSERT_NOW(a_desc_zero, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[OUT_TDATA_W-1:SMP_W] == '0,
        "descriptor set on a mid-block sample")

    // microseconds always normalized on a block end
    `PCM_DP_ASSERT_NOW(a_micros_range, m_axis_tvalid && m_axis_tlast,
        (m_axis_tdata[107:88] < US_PER_SECOND) && (m_axis_tdata[159:140] < US_PER_SECOND),
        "block microseconds out of range")

endmodule

bind pcm_audio_depacketizer_top pcm_dp_checker u_pcm_dp_checker (.*);
